>>> sv/byte_stream_find_and_replace_macros.svh
// Assertion macros for the find-and-replace checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef BYTE_STREAM_FIND_AND_REPLACE_MACROS_SVH
`define BYTE_STREAM_FIND_AND_REPLACE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BSFR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("find-and-replace check failed");

// Consequent must hold in the cycle after the antecedent.
`define BSFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("find-and-replace check failed");

`endif

>>> sv/bsfr_pkg.sv
`default_nettype none
package bsfr_pkg;

  localparam int MaxRepl  = 8;
  localparam int CntW     = $clog2(MaxRepl + 1);
  localparam int IdxW     = $clog2(MaxRepl);
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 64;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgPattern = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgRepl    = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgLen     = 8'd2;

  // one unit of back-end work: either a replacement burst or up to three
  // literal bytes, then possibly the end of the text
  typedef struct packed {
    logic            is_repl;
    logic [2:0][7:0] lits;
    logic [CntW-1:0] count;
    logic            done;
  } job_t;

  function automatic logic [CntW-1:0] clamp_len(input logic [3:0] len);
    if (len > 4'(MaxRepl)) begin
      return CntW'(MaxRepl);
    end
    return CntW'(len);
  endfunction

endpackage
`default_nettype wire

>>> sv/bsfr_if.sv
`default_nettype none
interface text_if import bsfr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_end;
  modport source (output valid, text_byte, text_end, input ready);
  modport sink   (input valid, text_byte, text_end, output ready);
  modport mon    (input valid, ready, text_byte, text_end);
endinterface

interface result_if import bsfr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       text_done;
  logic       run_last;
  modport source (output valid, out_byte, byte_present, text_done, run_last, input ready);
  modport sink   (input valid, out_byte, byte_present, text_done, run_last, output ready);
  modport mon    (input valid, ready, out_byte, byte_present, text_done, run_last);
endinterface

interface cfg_if import bsfr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
  modport mon    (input valid, ready, index, data);
endinterface
`default_nettype wire

>>> sv/bsfr_front.sv
`default_nettype none
module bsfr_front import bsfr_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  text_if.sink                 text,
  input  wire logic [23:0]     pattern,
  input  wire logic [CntW-1:0] repl_len,
  input  wire logic            q_ready,
  output logic                 push,
  output job_t                 job
);

  logic [7:0] p0, p1, p0_next, p1_next;
  logic [1:0] cnt, cnt_next;
  logic       accept, match;

  assign text.ready = q_ready;
  assign accept     = text.valid && q_ready;
  assign match      = (cnt == 2'd2) && ({text.text_byte, p1, p0} == pattern);

  always_comb begin
    job.is_repl = 1'b0;
    job.lits    = {text.text_byte, p1, p0};
    job.count   = '0;
    job.done    = text.text_end;
    p0_next     = p0;
    p1_next     = p1;
    cnt_next    = cnt;
    if (cnt == 2'd2) begin
      if (match) begin
        job.is_repl = 1'b1;
        job.count   = repl_len;
        cnt_next    = 2'd0;
      end else begin
        job.count = text.text_end ? CntW'(3) : CntW'(1);
        p0_next   = p1;
        p1_next   = text.text_byte;
      end
    end else if (cnt == 2'd1) begin
      job.lits  = {8'h00, text.text_byte, p0};
      job.count = text.text_end ? CntW'(2) : CntW'(0);
      p1_next   = text.text_byte;
      cnt_next  = 2'd2;
    end else begin
      job.lits  = {8'h00, 8'h00, text.text_byte};
      job.count = text.text_end ? CntW'(1) : CntW'(0);
      p0_next   = text.text_byte;
      cnt_next  = 2'd1;
    end
    // end of text flushes everything held
    if (text.text_end) begin
      cnt_next = 2'd0;
    end
  end

  // a word with nothing to emit and no end leaves no work behind
  assign push = accept && ((job.count != '0) || text.text_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (accept) begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p0 <= p0_next;
      p1 <= p1_next;
    end
  end

endmodule
`default_nettype wire

>>> sv/bsfr_queue.sv
`default_nettype none
module bsfr_queue import bsfr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      push_job,
  output logic      ready,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head_job
);

  job_t             slots [QDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QPtrW:0]   fill;
  logic             do_push, do_pop;

  assign ready      = (fill != (QPtrW + 1)'(QDepth));
  assign head_valid = (fill != '0);
  assign head_job   = slots[rd_ptr];
  assign do_push    = push && ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule
`default_nettype wire

>>> sv/bsfr_back.sv
`default_nettype none
module bsfr_back import bsfr_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  head_valid,
  input  job_t                       head_job,
  input  wire logic [MaxRepl*8-1:0]  repl,
  output logic                       pop,
  result_if.source                   result
);

  logic [MaxRepl-1:0][7:0] repl_arr;
  logic [IdxW-1:0]         idx;
  logic                    rv, out_free, gen, last;
  logic [7:0]              cur_byte;

  assign repl_arr = repl;
  assign out_free = !rv || result.ready;
  assign gen      = head_valid && out_free;
  assign last     = (head_job.count == '0) ||
                    (CntW'(idx) == (head_job.count - CntW'(1)));
  assign pop      = gen && last;

  always_comb begin
    if (head_job.is_repl) begin
      cur_byte = repl_arr[idx];
    end else if (idx == IdxW'(1)) begin
      cur_byte = head_job.lits[1];
    end else if (idx == IdxW'(2)) begin
      cur_byte = head_job.lits[2];
    end else begin
      cur_byte = head_job.lits[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv  <= 1'b0;
      idx <= '0;
    end else begin
      if (out_free) begin
        rv <= gen;
      end
      if (gen) begin
        idx <= last ? '0 : idx + 1'b1;
      end
    end
  end

  // output word register; holds while the sink stalls
  always_ff @(posedge clk) begin
    if (gen) begin
      result.out_byte     <= (head_job.count == '0) ? 8'h00 : cur_byte;
      result.byte_present <= (head_job.count != '0);
      result.text_done    <= last && head_job.done;
      result.run_last     <= last;
    end
  end

  assign result.valid = rv;

endmodule
`default_nettype wire

>>> sv/byte_stream_find_and_replace.sv
`default_nettype none
// Streaming find-and-replace on a byte stream. Text arrives one word per byte
// on the text channel; each non-overlapping occurrence of the 3-byte pattern,
// taken left to right, is replaced by the first replacement_length bytes of
// the replacement (lengths above eight count as eight). Up to two bytes are
// held back while they might still start a match. The front end takes one
// text word per cycle while the job queue has room and turns each word that
// leaves work into a job; a four-entry job queue feeds the back end, which
// emits one result word per cycle while the sink is ready. A plain byte gives
// one result word, a match replacement_length words and the end of a text up
// to three (one marker word if nothing is left to give); the back end's
// one-word-per-cycle emitter sets the sustained rate, and the queue absorbs
// short bursts so input keeps flowing meanwhile. Configuration words are
// taken at any time, but should only be written while the block is idle.
module byte_stream_find_and_replace import bsfr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  text_if.sink      text,
  result_if.source  result,
  cfg_if.sink       cfg
);

  logic [23:0]          pattern;
  logic [MaxRepl*8-1:0] repl;
  logic [3:0]           repl_len;
  logic [CntW-1:0]      len_sat;

  logic q_ready, push, pop, head_valid;
  job_t push_job, head_job;

  // configuration registers: always ready, unknown indexes dropped
  assign cfg.ready = 1'b1;
  assign len_sat   = clamp_len(repl_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern  <= '0;
      repl     <= '0;
      repl_len <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CfgPattern: pattern  <= cfg.data[23:0];
        CfgRepl:    repl     <= cfg.data[MaxRepl*8-1:0];
        CfgLen:     repl_len <= cfg.data[3:0];
        default: begin
        end
      endcase
    end
  end

  // front end: hold pending bytes, spot matches, build jobs
  bsfr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .text     (text),
    .pattern  (pattern),
    .repl_len (len_sat),
    .q_ready  (q_ready),
    .push     (push),
    .job      (push_job)
  );

  // decouple the two halves so each may stall on its own
  bsfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .ready      (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // back end: expand each job into result words
  bsfr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .repl       (repl),
    .pop        (pop),
    .result     (result)
  );

endmodule
`default_nettype wire

>>> sv/bsfr_checker.sv
`default_nettype none
`include "byte_stream_find_and_replace_macros.svh"
module bsfr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       valid,
  input wire logic       ready,
  input wire logic [7:0] out_byte,
  input wire logic       byte_present,
  input wire logic       text_done,
  input wire logic       run_last
);

  logic        stall;
  logic [10:0] word;
  assign stall = valid && !ready;
  assign word  = {out_byte, byte_present, text_done, run_last};

  `BSFR_ASSERT_NEXT(a_hold_valid, stall, valid)
  `BSFR_ASSERT_NEXT(a_hold_word, stall, $stable(word))
  `BSFR_ASSERT_NOW(a_marker, valid && !byte_present, text_done && run_last && (out_byte == 8'h00))
  `BSFR_ASSERT_NOW(a_done_last, valid && text_done, run_last)

endmodule

bind byte_stream_find_and_replace bsfr_checker u_bsfr_checker (
  .clk          (clk),
  .rst          (rst),
  .valid        (result.valid),
  .ready        (result.ready),
  .out_byte     (result.out_byte),
  .byte_present (result.byte_present),
  .text_done    (result.text_done),
  .run_last     (result.run_last)
);
`default_nettype wire

>>> test/byte_stream_find_and_replace_tb.sv
`timescale 1ns / 1ps
module byte_stream_find_and_replace_tb;
  import bsfr_pkg::*;

  // Register indexes past the end of the list; the block must ignore them.
  localparam logic [CfgIdxW-1:0] CfgSpare = CfgLen + 8'd1;
  localparam logic [CfgIdxW-1:0] CfgTop   = '1;

  // Quiet cycles after the last due word before a register write, and the
  // run-out at the end. Mid-text, a match with an empty replacement leaves no
  // word behind, and the front end puts no job for it in the job queue either.
  localparam int Drain = 24;
  // Cycles without any handshake before the run is called hung.
  localparam int HangLimit = 1000;
  localparam int PhaseWords = 36;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       text_done;
    logic       run_last;
  } rewritten_t;

  typedef enum logic [1:0] {RowText, RowReg} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [7:0]         text_byte;
    logic               text_end;
    logic [CfgIdxW-1:0] index;
    logic [63:0]        data;
    bit                 typed;
    rewritten_t         want;
  } row_t;

  logic clk = 1'b0;
  logic rst;

  text_if   text_ch ();
  result_if result_ch ();
  cfg_if    cfg_ch ();

  byte_stream_find_and_replace dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mirror of the block's registers and held bytes.
  logic [23:0] pat;
  logic [63:0] rep;
  logic [3:0]  rep_len;
  logic [7:0]  held [2];
  int          held_n;

  rewritten_t step_words[$];    // words caused by the latest text word
  rewritten_t rewritten_due[$]; // words still to come out, oldest first
  row_t       directed_rows[$];

  int  mismatches   = 0;
  int  text_words   = 0;
  int  result_words = 0;
  int  reg_writes   = 0;
  int  hang_cycles  = 0;
  int  stall_left   = 0;
  bit  calm         = 1'b0;

  function automatic rewritten_t mk_word(logic [7:0] b, logic present, logic done, logic last);
    rewritten_t w;
    w.out_byte     = b;
    w.byte_present = present;
    w.text_done    = done;
    w.run_last     = last;
    return w;
  endfunction

  // Work out the words one text word causes and advance the held state.
  function automatic void rewrite_step(logic [7:0] b, logic e);
    int n;
    step_words.delete();
    if (held_n >= 2) begin
      if ({b, held[1], held[0]} == pat) begin
        // lengths above the maximum count as the maximum
        n = (rep_len > 4'(MaxRepl)) ? MaxRepl : int'(rep_len);
        for (int i = 0; i < n; i++) begin
          step_words.push_back(mk_word(rep[8*i +: 8], 1'b1, 1'b0, 1'b0));
        end
        held_n = 0;
      end else begin
        // oldest byte can no longer start a match: pass it through
        step_words.push_back(mk_word(held[0], 1'b1, 1'b0, 1'b0));
        held[0] = held[1];
        held[1] = b;
      end
    end else begin
      held[held_n] = b;
      held_n++;
    end
    if (e) begin
      // flush what is held, then mark the end of the text
      for (int i = 0; i < held_n; i++) begin
        step_words.push_back(mk_word(held[i], 1'b1, 1'b0, 1'b0));
      end
      held_n  = 0;
      held[0] = '0;
      held[1] = '0;
      if (step_words.size() == 0) begin
        step_words.push_back(mk_word(8'h00, 1'b0, 1'b1, 1'b1));
      end else begin
        step_words[step_words.size()-1].text_done = 1'b1;
      end
    end
    if (step_words.size() != 0) begin
      step_words[step_words.size()-1].run_last = 1'b1;
    end
  endfunction

  function automatic row_t text_row(logic [7:0] b, logic e);
    row_t r;
    r.kind      = RowText;
    r.text_byte = b;
    r.text_end  = e;
    r.index     = '0;
    r.data      = '0;
    r.typed     = 1'b0;
    r.want      = '0;
    return r;
  endfunction

  // A text word whose single result is typed in by hand.
  function automatic row_t checked_row(logic [7:0] b, logic e, rewritten_t w);
    row_t r;
    r       = text_row(b, e);
    r.typed = 1'b1;
    r.want  = w;
    return r;
  endfunction

  function automatic row_t reg_row(logic [CfgIdxW-1:0] idx, logic [63:0] val);
    row_t r;
    r       = text_row(8'h00, 1'b0);
    r.kind  = RowReg;
    r.index = idx;
    r.data  = val;
    return r;
  endfunction

  // Offer one text word, possibly after a gap; hold valid high afterwards so
  // that the next word can follow back to back.
  task automatic send_text(logic [7:0] b, logic e, bit typed, rewritten_t want);
    if (!calm && $urandom_range(0, 7) == 0) begin
      text_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    text_ch.valid     <= 1'b1;
    text_ch.text_byte <= b;
    text_ch.text_end  <= e;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    rewrite_step(b, e);
    if (typed) begin
      rewritten_due.push_back(want);
    end else begin
      foreach (step_words[i]) rewritten_due.push_back(step_words[i]);
    end
    text_words++;
  endtask

  // Drop valid, wait for every due word, then let the back end run dry.
  task automatic settle();
    text_ch.valid <= 1'b0;
    while (rewritten_due.size() != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CfgPattern: pat     = val[23:0];
      CfgRepl:    rep     = val;
      CfgLen:     rep_len = val[3:0];
      default:    ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  // Receiver: stall in random bursts, check each accepted word against the
  // oldest due one.
  always @(posedge clk) begin
    rewritten_t got;
    rewritten_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = mk_word(result_ch.out_byte, result_ch.byte_present,
                    result_ch.text_done, result_ch.run_last);
      result_words++;
      if (rewritten_due.size() == 0) begin
        $error("result word %0h with nothing due", got);
        mismatches++;
      end else begin
        want = rewritten_due.pop_front();
        if (got.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
          mismatches++;
        end
        if (got.byte_present !== want.byte_present) begin
          $error("byte_present: expected %0b, got %0b", want.byte_present, got.byte_present);
          mismatches++;
        end
        if (got.text_done !== want.text_done) begin
          $error("text_done: expected %0b, got %0b", want.text_done, got.text_done);
          mismatches++;
        end
        if (got.run_last !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
          mismatches++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      result_ch.ready <= (stall_left == 0);
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 19);
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if ((text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      hang_cycles = 0;
    end else begin
      hang_cycles++;
    end
    if (hang_cycles >= HangLimit) begin
      $display("Watchdog: no handshake for %0d cycles", HangLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [7:0] text_buf[$];
    logic [7:0] pb;
    logic [7:0] fill;
    int         phase_words;
    int         target;
    int         pick;
    bit         paused;
    bit         prev_text;

    rst               = 1'b1;
    text_ch.valid     = 1'b0;
    text_ch.text_byte = '0;
    text_ch.text_end  = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    result_ch.ready   = 1'b0;
    pat               = '0;
    rep               = '0;
    rep_len           = '0;
    held[0]           = '0;
    held[1]           = '0;
    held_n            = 0;
    paused            = 1'b0;

    // Directed words. Reset leaves an all-zero pattern and an empty
    // replacement, so three zero bytes vanish and the end gives a marker.
    directed_rows.push_back(checked_row(8'h00, 1'b1, mk_word(8'h00, 1'b1, 1'b1, 1'b1)));
    directed_rows.push_back(checked_row(8'hFF, 1'b1, mk_word(8'hFF, 1'b1, 1'b1, 1'b1)));
    directed_rows.push_back(text_row(8'h00, 1'b0));
    directed_rows.push_back(text_row(8'h00, 1'b0));
    directed_rows.push_back(checked_row(8'h00, 1'b1, mk_word(8'h00, 1'b0, 1'b1, 1'b1)));
    directed_rows.push_back(text_row(8'h5A, 1'b0));
    directed_rows.push_back(text_row(8'hA5, 1'b1));
    // "abc" with an over-long length: the replacement saturates at eight bytes
    directed_rows.push_back(reg_row(CfgPattern, 64'h0000_0000_0063_6261));
    directed_rows.push_back(reg_row(CfgRepl, 64'h00FF_7F80_0155_AAFE));
    directed_rows.push_back(reg_row(CfgLen, 64'hF));
    directed_rows.push_back(text_row(8'h61, 1'b0));
    directed_rows.push_back(text_row(8'h62, 1'b0));
    directed_rows.push_back(text_row(8'h63, 1'b1));
    // a false start, then a match, then a byte flushed at the end
    directed_rows.push_back(text_row(8'h61, 1'b0));
    directed_rows.push_back(text_row(8'h61, 1'b0));
    directed_rows.push_back(text_row(8'h62, 1'b0));
    directed_rows.push_back(text_row(8'h63, 1'b0));
    directed_rows.push_back(text_row(8'h64, 1'b1));
    // writes to indexes past the list must change nothing
    directed_rows.push_back(reg_row(CfgLen, 64'h8));
    directed_rows.push_back(reg_row(CfgSpare, '1));
    directed_rows.push_back(reg_row(CfgTop, '1));
    directed_rows.push_back(text_row(8'h61, 1'b0));
    directed_rows.push_back(text_row(8'h62, 1'b0));
    directed_rows.push_back(text_row(8'h63, 1'b0));
    directed_rows.push_back(checked_row(8'h7E, 1'b1, mk_word(8'h7E, 1'b1, 1'b1, 1'b1)));
    // all-ones pattern over a run of five: one match, two bytes flushed
    directed_rows.push_back(reg_row(CfgPattern, 64'h0000_0000_00FF_FFFF));
    directed_rows.push_back(reg_row(CfgLen, 64'h1));
    directed_rows.push_back(text_row(8'hFF, 1'b0));
    directed_rows.push_back(text_row(8'hFF, 1'b0));
    directed_rows.push_back(text_row(8'hFF, 1'b0));
    directed_rows.push_back(text_row(8'hFF, 1'b0));
    directed_rows.push_back(text_row(8'hFF, 1'b1));
    // empty replacement mid-text: that word causes nothing at all
    directed_rows.push_back(reg_row(CfgLen, 64'h0));
    directed_rows.push_back(text_row(8'hFF, 1'b0));
    directed_rows.push_back(text_row(8'hFF, 1'b0));
    directed_rows.push_back(text_row(8'hFF, 1'b0));
    directed_rows.push_back(checked_row(8'hFF, 1'b1, mk_word(8'hFF, 1'b1, 1'b1, 1'b1)));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    prev_text = 1'b0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == RowReg) begin
        if (prev_text) settle();
        write_reg(directed_rows[i].index, directed_rows[i].data);
        prev_text = 1'b0;
      end else begin
        send_text(directed_rows[i].text_byte, directed_rows[i].text_end,
                  directed_rows[i].typed, directed_rows[i].want);
        prev_text = 1'b1;
      end
    end

    // Random phases: each with its own setting, texts seeded with pattern
    // bytes and whole patterns so that matches and near misses are common.
    for (int phase = 0; phase < 5; phase++) begin
      settle();
      calm = (phase == 4);
      pb   = 8'($urandom);
      case (phase)
        0: begin
          write_reg(CfgPattern, 64'($urandom_range(0, 24'hFF_FFFF)));
          write_reg(CfgLen, 64'h8);
        end
        1: begin
          // one byte repeated: tests the non-overlapping rule
          write_reg(CfgPattern, 64'({pb, pb, pb}));
          write_reg(CfgLen, 64'hF);
        end
        2: begin
          write_reg(CfgPattern, 64'({pb, 8'($urandom), pb}));
          write_reg(CfgLen, 64'h0);
        end
        3: begin
          write_reg(CfgPattern, 64'($urandom_range(0, 24'hFF_FFFF)));
          write_reg(CfgLen, 64'($urandom_range(1, 7)));
          write_reg(CfgSpare, {$urandom, $urandom});
        end
        default: begin
          write_reg(CfgPattern, 64'({8'($urandom), pb, pb}));
          write_reg(CfgLen, 64'($urandom_range(0, 15)));
        end
      endcase
      write_reg(CfgRepl, {$urandom, $urandom});

      phase_words = 0;
      while (phase_words < PhaseWords) begin
        // hold off once until the block has drained completely
        if (phase == 1 && !paused && phase_words > 20) begin
          settle();
          paused = 1'b1;
        end
        text_buf.delete();
        target = ($urandom_range(0, 9) == 0) ? 20 : $urandom_range(1, 10);
        fill   = ($urandom_range(0, 6) == 0) ? 8'd10 : 8'd0; // some pure noise
        while (text_buf.size() < target) begin
          pick = $urandom_range(0, 9);
          if (fill != 0 || pick >= 7) begin
            text_buf.push_back(8'($urandom));
          end else if (pick < 3) begin
            text_buf.push_back(pat[7:0]);
            text_buf.push_back(pat[15:8]);
            text_buf.push_back(pat[23:16]);
          end else begin
            text_buf.push_back(pat[8*$urandom_range(0, 2) +: 8]);
          end
        end
        foreach (text_buf[i]) begin
          send_text(text_buf[i], i == text_buf.size() - 1, 1'b0, '0);
        end
        phase_words += text_buf.size();
      end
    end

    settle();
    $display("Covered %0d text words and %0d result words across %0d register writes",
             text_words, result_words, reg_writes);
    $display("Settings ran from empty to saturated replacements and repeated-byte patterns");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/bsfr_pkg.sv
sv/bsfr_if.sv
sv/bsfr_front.sv
sv/bsfr_queue.sv
sv/bsfr_back.sv
sv/byte_stream_find_and_replace.sv
sv/bsfr_checker.sv
test/byte_stream_find_and_replace_tb.sv
